/* hw/rtl/block_crc32c_verifier_unit_macros.svh */
// Assertion macros used by the verification checker.
`ifndef BLOCK_CRC32C_VERIFIER_UNIT_MACROS_SVH
`define BLOCK_CRC32C_VERIFIER_UNIT_MACROS_SVH

// Property checked outside reset.
`define BCV_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every edge, reset included.
`define BCV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/bcv_pkg.sv */
// Types, constants and the CRC-32C byte update for the block checksum verifier.
package bcv_pkg;

  localparam int MAX_BLOCK_BYTES  = 65536;
  localparam int CSUM_FIELD_BYTES = 32;
  localparam int POS_W            = 17;
  localparam int KIND_W           = 2;
  localparam int CRC_W            = 32;
  localparam int APB_ADDR_W       = 3;
  localparam int APB_DATA_W       = 32;
  localparam int OUT_FIELDS_W     = 1 + 2 * CRC_W;
  localparam int OUT_W            = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CRC_W-1:0]  CRC_POLY   = 32'h82f6_3b78;
  localparam logic [CRC_W-1:0]  CRC_INIT   = 32'hffff_ffff;
  localparam logic [POS_W-1:0]  LEN_RESET  = POS_W'(4096);
  localparam logic [POS_W-1:0]  LEN_MIN    = POS_W'(CSUM_FIELD_BYTES + 1);
  localparam logic [POS_W-1:0]  LEN_MAX    = POS_W'(MAX_BLOCK_BYTES);
  localparam logic [POS_W-1:0]  FIELD_END  = POS_W'(CSUM_FIELD_BYTES);
  localparam logic [POS_W-1:0]  STORED_END = POS_W'(4);

  localparam logic [KIND_W-1:0] KIND_CRC32C = 2'd0;

  // register index as decoded from paddr[2]
  localparam logic REG_KIND   = 1'b0;
  localparam logic REG_LENGTH = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  length;
  } cfg_t;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] rem,
                                                input logic [7:0] b);
    logic [CRC_W-1:0] r;
    r = rem ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

/* hw/rtl/bcv_cfg_regs.sv */
// APB register file: checksum kind and block length.
module bcv_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bcv_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [bcv_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [bcv_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output bcv_pkg::cfg_t                    cfg
);
  import bcv_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kind   <= KIND_CRC32C;
      cfg.length <= LEN_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_KIND:   cfg.kind   <= pwdata[KIND_W-1:0];
        REG_LENGTH: cfg.length <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_KIND:   prdata = {{(APB_DATA_W-KIND_W){1'b0}}, cfg.kind};
      REG_LENGTH: prdata = {{(APB_DATA_W-POS_W){1'b0}}, cfg.length};
      default:    prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/block_crc32c_verifier_unit.sv */
// Block checksum verifier top level: CRC-32C check of one block per run of bytes.
//
// Input stream s_axis: one byte per word in tdata[7:0], offset zero first.
// Bytes 0..3 are the stored checksum (little-endian), bytes 4..31 are skipped,
// the rest feed a reflected CRC-32C. block_length (APB, address 4) sets the
// bytes per block, clamped to 33..65536; checksum_kind (address 0) must be 0
// for a pass. Write configuration only while idle.
// Output stream m_axis: one word per block, given after its last byte:
//   tdata[0] checksum_ok, [32:1] computed_crc, [64:33] stored_crc, [71:65] zero.
// Throughput: one byte per cycle except in the stall below; the byte-wide CRC
// update between the input register and the block state registers is the single
// stage of work. Result path: the input register, then the result register.
// Stall: while the result register is full and not taken, the input stalls only
// once the last byte of the next block reaches the input register; earlier bytes
// still flow at full rate.
// Reset: config returns to crc32c / 4096 bytes, any partial block is dropped.
module block_crc32c_verifier_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bcv_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [bcv_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [bcv_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,   // data_byte
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [bcv_pkg::OUT_W-1:0]        m_axis_tdata    // checksum_ok, computed_crc,
                                                           // stored_crc, zero pad
);
  import bcv_pkg::*;

  cfg_t              cfg;
  logic              in_valid;
  logic [7:0]        in_byte;
  logic [POS_W-1:0]  pos;
  logic [CRC_W-1:0]  crc;
  logic [CRC_W-1:0]  stored;
  logic              out_valid;
  logic [OUT_W-1:0]  out_data;

  logic [POS_W-1:0]  len_eff;
  logic [POS_W-1:0]  pos_next;
  logic              is_last;
  logic [CRC_W-1:0]  crc_next;
  logic [CRC_W-1:0]  stored_next;
  logic [CRC_W-1:0]  computed;
  logic              ok;
  logic              advance;

  bcv_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_comb begin
    if (cfg.length < LEN_MIN) begin
      len_eff = LEN_MIN;
    end else if (cfg.length > LEN_MAX) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = cfg.length;
    end
  end

  assign pos_next = pos + POS_W'(1);
  assign is_last  = pos_next >= len_eff;

  always_comb begin
    stored_next = stored;
    if (pos < STORED_END) begin
      stored_next[{pos[1:0], 3'b000} +: 8] = in_byte;
    end
  end

  assign crc_next = (pos >= FIELD_END) ? crc_byte(crc, in_byte) : crc;
  assign computed = ~crc_next;
  assign ok       = (cfg.kind == KIND_CRC32C) && (stored_next == computed);

  // only a block-ending byte needs room in the result register
  assign advance       = in_valid && (!is_last || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      crc    <= CRC_INIT;
      stored <= '0;
    end else if (advance) begin
      if (is_last) begin
        pos    <= '0;
        crc    <= CRC_INIT;
        stored <= '0;
      end else begin
        pos    <= pos_next;
        crc    <= crc_next;
        stored <= stored_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && is_last) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_last) begin
      out_data <= {{(OUT_W-OUT_FIELDS_W){1'b0}}, stored_next, computed, ok};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

/* hw/rtl/bcv_checker.sv */
// Port-level checker for the block checksum verifier, bound to the top level.
`include "block_crc32c_verifier_unit_macros.svh"

module bcv_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [bcv_pkg::OUT_W-1:0]  m_axis_tdata
);
  import bcv_pkg::*;

  `BCV_ASSERT_ALWAYS(a_reset_no_word, clk, rst |=> !m_axis_tvalid, "result word right after reset")

  `BCV_ASSERT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result word changed")

  `BCV_ASSERT(a_pass_match, clk, rst, m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[CRC_W:1] == m_axis_tdata[2*CRC_W:CRC_W+1], "pass flagged with differing checksums")

  `BCV_ASSERT(a_pad_zero, clk, rst, m_axis_tvalid |-> m_axis_tdata[OUT_W-1:OUT_FIELDS_W] == '0, "padding bits not zero")

  `BCV_ASSERT(a_ready_when_empty, clk, rst, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty result register")

endmodule

bind block_crc32c_verifier_unit bcv_checker u_bcv_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
